// ===== src/assert_macros.svh =====
// Assertion macros shared by the modules that carry concurrent checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/msd_pkg.sv =====
// Shared constants, types and helper functions of the mean squared displacement block.
// No dependencies; every module refers to it by scoped names.
package msd_pkg;

    localparam int MAX_ATOMS  = 4096;
    localparam int COORD_BITS = 32;

    localparam int IDX_W   = 12;
    localparam int ADDR_W  = $clog2(MAX_ATOMS);
    localparam int POS_W   = 32;
    localparam int TS_W    = 48;
    localparam int CNT_W   = 13;
    localparam int FRAME_W = 16;
    localparam int SUM_W   = 64;
    localparam int SQ_W    = 47;
    localparam int MSD_W   = 47;
    localparam int TOT_W   = 48;
    localparam int DIFF_W  = 25;
    localparam int DIV_STEP_W = $clog2(SUM_W);

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 256;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ATOM_COUNT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = CFG_IDX_W'(1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic signed [POS_W:0] SAT_HI = (POS_W+1)'(64'sd8388608);
    localparam logic signed [POS_W:0] SAT_LO = -SAT_HI;

    typedef struct packed {
        logic               first;
        logic               last;
        logic [FRAME_W-1:0] frame_number;
        logic [TS_W-1:0]    timestep;
        logic [CNT_W-1:0]   count;
    } t_tag;

    typedef struct packed {
        t_tag             tag;
        logic [IDX_W-1:0] atom_index;
        logic             in_range;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef logic [2:0][SUM_W-1:0] t_sum3;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    // Sign-extends the coordinate from its used width to the full field width.
    function automatic logic [POS_W-1:0] coord_ext(input logic [POS_W-1:0] raw);
        return POS_W'(signed'(raw[COORD_BITS-1:0]));
    endfunction

    // Current minus reference, clamped to plus or minus two to the 23rd.
    function automatic logic [DIFF_W-1:0] sat_diff(input logic [POS_W-1:0] cur,
                                                   input logic [POS_W-1:0] refv);
        logic signed [POS_W:0] d;
        d = $signed({cur[POS_W-1], cur}) - $signed({refv[POS_W-1], refv});
        if (d > SAT_HI) begin
            return DIFF_W'(SAT_HI);
        end else if (d < SAT_LO) begin
            return DIFF_W'(SAT_LO);
        end
        return d[DIFF_W-1:0];
    endfunction

endpackage

// ===== src/mean_squared_displacement.sv =====
// Mean squared displacement over a stream of atom positions, one atom per item.
// Top level: configuration registers, front end, item queue and arithmetic back end.
// Depends on msd_pkg, msd_front, msd_queue, msd_back and assert_macros.svh.
//
// Items are taken at one per clock while the back end keeps pace; the back end
// runs a four-stage pipeline (reference read, clamped difference, square,
// accumulate) through a single-port reference memory. When the last atom of a
// frame enters, the back end takes no further items until the three-lane
// divider has produced the means and the result has moved into the output
// register; the four-entry queue keeps taking items in that time and then
// stalls the input. Frames of a few hundred atoms or more therefore run at
// close to one item per clock. The reference memory is not cleared after
// reset: frame one writes every entry that later frames read.
`include "assert_macros.svh"

module mean_squared_displacement (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // atom_index, pos_x, pos_y, pos_z, frame_timestep, zero fill (low bit up)
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [msd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // frame_number, timestep_out, msd_x, msd_y, msd_z, msd_sum, zero fill (low bit up)
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [msd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [msd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [msd_pkg::CNT_W-1:0]   r_atom_count;
    logic [msd_pkg::FRAME_W-1:0] r_frame_limit;
    logic                        push;
    logic                        pop;
    msd_pkg::t_item              front_item;
    msd_pkg::t_item              head_item;
    msd_pkg::t_q_status          q_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atom_count  <= msd_pkg::CNT_W'(4096);
            r_frame_limit <= msd_pkg::FRAME_W'(65535);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                msd_pkg::CFG_ATOM_COUNT:  r_atom_count  <= i_cfg_data[msd_pkg::CNT_W-1:0];
                msd_pkg::CFG_FRAME_LIMIT: r_frame_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    msd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_atom_count  (r_atom_count),
        .i_frame_limit (r_frame_limit),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_item        (front_item)
    );

    msd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    msd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (head_item),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `ASSERT_IMPLIES(a_no_push_full, i_clk, i_rst_n, push, !q_status.full, "push into full queue")
    `ASSERT_IMPLIES(a_no_pop_empty, i_clk, i_rst_n, pop, !q_status.empty, "pop from empty queue")
    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, push && !pop, !q_status.empty, "pushed item lost")

endmodule

// ===== src/msd_front.sv =====
// Front end: accepts position items, counts atoms and frames, drops items past the limit.
// Depends on msd_pkg; feeds msd_queue.
module msd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [msd_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [msd_pkg::CNT_W-1:0]     i_atom_count,
    input  logic [msd_pkg::FRAME_W-1:0]   i_frame_limit,
    input  msd_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output msd_pkg::t_item                o_item
);

    logic [msd_pkg::CNT_W-1:0]   r_seen;
    logic [msd_pkg::CNT_W-1:0]   n_seen;
    logic [msd_pkg::FRAME_W-1:0] r_frames;
    logic [msd_pkg::FRAME_W-1:0] n_frames;
    logic [msd_pkg::CNT_W-1:0]   eff_count;
    logic [msd_pkg::CNT_W-1:0]   seen_inc;
    logic                        accept;
    logic                        ignore;
    logic                        last;
    logic [msd_pkg::IDX_W-1:0]   idx;

    assign s_axis_tready = !i_q_status.full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ignore        = r_frames >= i_frame_limit;
    assign seen_inc      = r_seen + msd_pkg::CNT_W'(1);
    assign last          = seen_inc >= eff_count;
    assign o_push        = accept && !ignore;
    assign idx           = s_axis_tdata[11:0];

    always_comb begin
        priority if (i_atom_count == '0) begin
            eff_count = msd_pkg::CNT_W'(1);
        end else if (i_atom_count > msd_pkg::CNT_W'(msd_pkg::MAX_ATOMS)) begin
            eff_count = msd_pkg::CNT_W'(msd_pkg::MAX_ATOMS);
        end else begin
            eff_count = i_atom_count;
        end
    end

    always_comb begin
        n_seen   = r_seen;
        n_frames = r_frames;
        if (o_push) begin
            if (last) begin
                n_seen   = '0;
                n_frames = r_frames + msd_pkg::FRAME_W'(1);
            end else begin
                n_seen = seen_inc;
            end
        end
    end

    always_comb begin
        o_item.tag.first        = r_frames == '0;
        o_item.tag.last         = last;
        o_item.tag.frame_number = r_frames + msd_pkg::FRAME_W'(1);
        o_item.tag.timestep     = s_axis_tdata[155:108];
        o_item.tag.count        = eff_count;
        o_item.atom_index       = idx;
        o_item.in_range         = {1'b0, idx} < (msd_pkg::IDX_W+1)'(msd_pkg::MAX_ATOMS);
        o_item.pos_x            = msd_pkg::coord_ext(s_axis_tdata[43:12]);
        o_item.pos_y            = msd_pkg::coord_ext(s_axis_tdata[75:44]);
        o_item.pos_z            = msd_pkg::coord_ext(s_axis_tdata[107:76]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= '0;
            r_frames <= '0;
        end else begin
            r_seen   <= n_seen;
            r_frames <= n_frames;
        end
    end

endmodule

// ===== src/msd_queue.sv =====
// Short item queue that decouples the front end from the arithmetic back end.
// Depends on msd_pkg for the item type and depth.
module msd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  msd_pkg::t_item     i_item,
    input  logic               i_pop,
    output msd_pkg::t_item     o_item,
    output msd_pkg::t_q_status o_status
);

    msd_pkg::t_item                r_entries [msd_pkg::QUEUE_DEPTH];
    logic [msd_pkg::QPTR_W-1:0]    r_wr;
    logic [msd_pkg::QPTR_W-1:0]    r_rd;
    logic [msd_pkg::QPTR_W:0]      r_level;

    assign o_status.full  = r_level == (msd_pkg::QPTR_W+1)'(msd_pkg::QUEUE_DEPTH);
    assign o_status.empty = r_level == '0;
    assign o_item         = r_entries[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + msd_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + msd_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + (msd_pkg::QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_level <= r_level - (msd_pkg::QPTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== src/msd_div.sv =====
// Three-lane restoring divider, one quotient bit per lane per cycle, shared divisor.
// Depends on msd_pkg; used by msd_back for the per-frame means.
module msd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  msd_pkg::t_sum3            i_dividend,
    input  logic [msd_pkg::CNT_W-1:0] i_divisor,
    input  logic                      i_ack,
    output logic                      o_done,
    output msd_pkg::t_sum3            o_quot
);

    msd_pkg::t_div_state              r_state;
    msd_pkg::t_div_state              n_state;
    logic [msd_pkg::DIV_STEP_W-1:0]   r_step;
    logic [msd_pkg::CNT_W-1:0]        r_divisor;
    msd_pkg::t_sum3                   r_work;
    msd_pkg::t_sum3                   n_work;
    logic [2:0][msd_pkg::CNT_W-1:0]   r_rem;
    logic [2:0][msd_pkg::CNT_W-1:0]   n_rem;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msd_pkg::DIV_IDLE: begin
                if (i_start) begin
                    n_state = msd_pkg::DIV_RUN;
                end
            end
            msd_pkg::DIV_RUN: begin
                if (r_step == '0) begin
                    n_state = msd_pkg::DIV_DONE;
                end
            end
            msd_pkg::DIV_DONE: begin
                if (i_ack) begin
                    n_state = msd_pkg::DIV_IDLE;
                end
            end
            default: n_state = msd_pkg::DIV_IDLE;
        endcase
    end

    always_comb begin
        o_done = r_state == msd_pkg::DIV_DONE;
        o_quot = r_work;
    end

    always_comb begin
        logic [msd_pkg::CNT_W:0] trial;
        logic                    ge;
        for (int l = 0; l < 3; l++) begin
            trial    = {r_rem[l], r_work[l][msd_pkg::SUM_W-1]};
            ge       = trial >= {1'b0, r_divisor};
            n_rem[l] = ge ? msd_pkg::CNT_W'(trial - {1'b0, r_divisor})
                          : trial[msd_pkg::CNT_W-1:0];
            n_work[l] = {r_work[l][msd_pkg::SUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msd_pkg::DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == msd_pkg::DIV_IDLE && i_start) begin
            r_work    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_step    <= msd_pkg::DIV_STEP_W'(msd_pkg::SUM_W - 1);
        end else if (r_state == msd_pkg::DIV_RUN) begin
            r_work <= n_work;
            r_rem  <= n_rem;
            r_step <= r_step - msd_pkg::DIV_STEP_W'(1);
        end
    end

endmodule

// ===== src/msd_back.sv =====
// Back end: reference store, displacement, squaring, accumulation and the result register.
// Depends on msd_pkg and msd_div; takes items from msd_queue.
module msd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  msd_pkg::t_item                 i_item,
    input  msd_pkg::t_q_status             i_q_status,
    output logic                           o_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [msd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic [3*msd_pkg::POS_W-1:0] r_mem [msd_pkg::MAX_ATOMS];
    logic [3*msd_pkg::POS_W-1:0] r_rd_data;
    logic [msd_pkg::ADDR_W-1:0]  addr;

    logic                          r_frame_busy;
    logic                          r_s1_valid;
    msd_pkg::t_item                r_s1;
    logic                          r_s2_valid;
    msd_pkg::t_tag                 r_s2_tag;
    logic [2:0][msd_pkg::DIFF_W-1:0] r_d;
    logic                          r_s3_valid;
    msd_pkg::t_tag                 r_s3_tag;
    logic [2:0][msd_pkg::SQ_W-1:0] r_sq;
    msd_pkg::t_sum3                r_sum;
    msd_pkg::t_sum3                n_sum;
    msd_pkg::t_tag                 r_res_tag;

    logic [2:0][msd_pkg::POS_W-1:0]  cur;
    logic [2:0][msd_pkg::POS_W-1:0]  refv;
    logic [2:0][msd_pkg::DIFF_W-1:0] diff;
    logic [2:0][msd_pkg::SQ_W-1:0]   sq;

    logic                    div_start;
    logic                    div_done;
    msd_pkg::t_sum3          div_quot;
    logic                    load;
    logic [msd_pkg::MSD_W-1:0] mx;
    logic [msd_pkg::MSD_W-1:0] my;
    logic [msd_pkg::MSD_W-1:0] mz;
    logic [msd_pkg::TOT_W-1:0] total;

    logic                          r_out_valid;
    logic [msd_pkg::OUT_DATA_W-1:0] r_out_data;

    assign o_pop = !i_q_status.empty && !r_frame_busy;
    assign addr  = i_item.atom_index[msd_pkg::ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.in_range) begin
            if (i_item.tag.first) begin
                r_mem[addr] <= {i_item.pos_z, i_item.pos_y, i_item.pos_x};
            end else begin
                r_rd_data <= r_mem[addr];
            end
        end
    end

    always_comb begin
        cur[0] = r_s1.pos_x;
        cur[1] = r_s1.pos_y;
        cur[2] = r_s1.pos_z;
        for (int l = 0; l < 3; l++) begin
            refv[l] = (r_s1.in_range && !r_s1.tag.first)
                    ? r_rd_data[l*msd_pkg::POS_W +: msd_pkg::POS_W] : '0;
            diff[l] = msd_pkg::sat_diff(cur[l], refv[l]);
        end
    end

    always_comb begin
        logic signed [2*msd_pkg::DIFF_W-1:0] prod;
        for (int l = 0; l < 3; l++) begin
            prod  = $signed(r_d[l]) * $signed(r_d[l]);
            sq[l] = prod[msd_pkg::SQ_W-1:0];
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_sum[l] = r_s3_tag.first ? r_sum[l]
                                      : r_sum[l] + msd_pkg::SUM_W'(r_sq[l]);
        end
    end

    assign div_start = r_s3_valid && r_s3_tag.last;

    msd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (r_s3_tag.count),
        .i_ack      (load),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign load  = div_done && (!r_out_valid || m_axis_tready);
    assign mx    = div_quot[0][msd_pkg::MSD_W-1:0];
    assign my    = div_quot[1][msd_pkg::MSD_W-1:0];
    assign mz    = div_quot[2][msd_pkg::MSD_W-1:0];
    assign total = msd_pkg::TOT_W'(mx) + msd_pkg::TOT_W'(my) + msd_pkg::TOT_W'(mz);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_item;
        end
        r_s2_tag <= r_s1.tag;
        r_d      <= diff;
        r_s3_tag <= r_s2_tag;
        r_sq     <= sq;
        if (div_start) begin
            r_res_tag <= r_s3_tag;
        end
        if (load) begin
            r_out_data <= {3'b000, total, mz, my, mx,
                           r_res_tag.timestep, r_res_tag.frame_number};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_busy <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_s1_valid <= o_pop;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (o_pop && i_item.tag.last) begin
                r_frame_busy <= 1'b1;
            end else if (load) begin
                r_frame_busy <= 1'b0;
            end
            if (r_s3_valid) begin
                r_sum <= r_s3_tag.last ? '0 : n_sum;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
